### rtl/itrd_pkg.sv
// Package: shared constants, types and a helper function of the radix digit converter.
`timescale 1ns / 1ps
`default_nettype none
package itrd_pkg;

	localparam int VALUE_W       = 32;
	localparam int CHAR_W        = 8;
	localparam int DIGIT_W       = 4;
	localparam int RADIX_W       = 5;
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_INDEX_W   = 2;
	localparam int BITS_PER_STEP = 8;
	localparam int DIV_STEPS     = VALUE_W / BITS_PER_STEP;
	localparam int STEP_CNT_W    = $clog2(DIV_STEPS);

	localparam int MAX_DIGITS_DEF = 32;
	localparam int MAX_RADIX_DEF  = 16;

	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [CHAR_W-1:0]  MINUS_CHAR  = 8'h2D;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_RADIX     = 2'd0,
		REG_ALPHA_LOW = 2'd1,
		REG_ALPHA_HI  = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	// Looks up the byte code of one digit value in the 16-entry alphabet.
	function automatic logic [CHAR_W-1:0] symbol_for(
		input logic [CFG_DATA_W-1:0] alpha_low,
		input logic [CFG_DATA_W-1:0] alpha_high,
		input logic [DIGIT_W-1:0]    digit
	);
		logic [CFG_DATA_W-1:0] word;
		word = digit[DIGIT_W-1] ? alpha_high : alpha_low;
		return word[{digit[DIGIT_W-2:0], 3'b000} +: CHAR_W];
	endfunction

endpackage
`default_nettype wire

### rtl/itrd_if.sv
// Interfaces: the integer input channel and the character output channel.
`timescale 1ns / 1ps
`default_nettype none
interface itrd_value_if
	import itrd_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface itrd_char_if
	import itrd_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	logic              last;

	modport source (output valid, output character, output last, input ready);
	modport sink   (input valid, input character, input last, output ready);
endinterface
`default_nettype wire

### rtl/integer_to_radix_digits_core.sv
// Top level: signed integer to text conversion in a configurable radix.
`timescale 1ns / 1ps
`default_nettype none
// Usage
// The number channel (valid/ready) carries one signed 32-bit value per
// transaction. The text channel returns its characters one transaction each,
// most significant first, with a leading minus sign for negative values;
// last is high on the final character of the number.
// Configuration goes through a plain write port: cfg_we, cfg_index and
// cfg_data. Index 0 is the radix (clamped to 2..MAX_RADIX), indexes 1 and 2
// are the low and high halves of the 16-entry alphabet. Write it only while
// the block is idle.
// Timing: a single shared long-division unit retires 8 dividend bits per
// cycle. Once the last digit is divided, the sign, if any, goes to the
// output register; then each digit passes through the registered read
// port, and the digits follow one per cycle while the receiver takes them. The number
// channel stays not ready until the last digit has moved to the output
// register, so the next transaction can be taken while that character waits.
// Reset clears the sequencer and the output valid flag and restores radix 10 and
// an all-zero alphabet. When the receiver stalls, the current character
// holds in the output register and emission simply pauses.
module integer_to_radix_digits_core
	import itrd_pkg::*;
#(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF,
	parameter int MAX_RADIX  = MAX_RADIX_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	itrd_value_if.sink                  number,
	itrd_char_if.source                 text,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
	localparam int ADDR_W = $clog2(MAX_DIGITS);

	// Configuration registers.
	logic [RADIX_W-1:0]    radix_q;
	logic [CFG_DATA_W-1:0] alpha_low_q;
	logic [CFG_DATA_W-1:0] alpha_high_q;
	logic [RADIX_W-1:0]    radix_wr;

	// Sequencer and division datapath.
	state_t                state_q, state_d;
	logic                  neg_q;
	logic [VALUE_W-1:0]    work_q;
	logic [DIGIT_W-1:0]    rem_q;
	logic [STEP_CNT_W-1:0] step_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [VALUE_W-1:0]    div_work;
	logic [DIGIT_W-1:0]    div_rem;

	// Digit memory and its registered read port.
	logic [DIGIT_W-1:0]    digit_mem [MAX_DIGITS];
	logic [DIGIT_W-1:0]    rd_q;
	logic                  rd_valid_q;
	logic                  rd_last_q;
	logic [ADDR_W-1:0]     rd_addr;

	// Output register.
	logic                  out_valid_q;
	logic [CHAR_W-1:0]     out_char_q;
	logic                  out_last_q;
	logic                  out_free;

	// Control strobes from the sequencer.
	logic in_take, div_step, digit_done, div_more, sign_load, dig_load, rd_issue;

	// Radix writes are clamped into the supported range.
	always_comb begin
		if (cfg_data[RADIX_W-1:0] < RADIX_MIN) begin
			radix_wr = RADIX_MIN;
		end else if (int'(cfg_data[RADIX_W-1:0]) > MAX_RADIX) begin
			radix_wr = RADIX_W'(MAX_RADIX);
		end else begin
			radix_wr = cfg_data[RADIX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q      <= RADIX_RESET;
			alpha_low_q  <= '0;
			alpha_high_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RADIX:     radix_q      <= radix_wr;
				REG_ALPHA_LOW: alpha_low_q  <= cfg_data;
				REG_ALPHA_HI:  alpha_high_q <= cfg_data;
				default:       ;
			endcase
		end
	end

	// Shared restoring divider: eight quotient bits per cycle. The dividend
	// shifts out of the top of the work word while quotient bits enter at
	// the bottom, so after four steps the work word holds the quotient.
	always_comb begin
		logic [DIGIT_W:0] trial;
		logic [DIGIT_W-1:0] r;
		logic [VALUE_W-1:0] w;
		r = rem_q;
		w = work_q;
		for (int k = 0; k < BITS_PER_STEP; k++) begin
			trial = {r, w[VALUE_W-1]};
			w     = {w[VALUE_W-2:0], 1'b0};
			if (trial >= radix_q) begin
				trial = trial - radix_q;
				w[0]  = 1'b1;
			end
			r = trial[DIGIT_W-1:0];
		end
		div_work = w;
		div_rem  = r;
	end

	assign out_free = !out_valid_q || text.ready;
	assign rd_addr  = ADDR_W'(cnt_q - CNT_W'(1));
	assign div_more = (div_work != '0) && (int'(cnt_q) + 1 < MAX_DIGITS);

	// Sequencer: next state and control strobes.
	always_comb begin
		state_d    = state_q;
		in_take    = 1'b0;
		div_step   = 1'b0;
		digit_done = 1'b0;
		sign_load  = 1'b0;
		dig_load   = 1'b0;
		rd_issue   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (number.valid) begin
					in_take = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				div_step = 1'b1;
				if (step_q == STEP_CNT_W'(DIV_STEPS - 1)) begin
					digit_done = 1'b1;
					if (!div_more) begin
						state_d = neg_q ? ST_SIGN : ST_EMIT;
					end
				end
			end
			ST_SIGN: begin
				if (out_free) begin
					sign_load = 1'b1;
					state_d   = ST_EMIT;
				end
			end
			ST_EMIT: begin
				dig_load = out_free && rd_valid_q;
				rd_issue = (cnt_q != '0) && (!rd_valid_q || dig_load);
				if (cnt_q == '0 && !rd_valid_q) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign number.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			step_q     <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_take) begin
				cnt_q  <= '0;
				step_q <= '0;
			end else if (div_step) begin
				step_q <= step_q + STEP_CNT_W'(1);
				if (digit_done) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end else if (rd_issue) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (rd_issue) begin
				rd_valid_q <= 1'b1;
			end else if (dig_load) begin
				rd_valid_q <= 1'b0;
			end
		end
	end

	// Division payload; the remainder restarts at zero for every digit.
	always_ff @(posedge clk) begin
		if (in_take) begin
			neg_q  <= number.value[VALUE_W-1];
			work_q <= number.value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(number.value))
			                                  : VALUE_W'(number.value);
			rem_q  <= '0;
		end else if (div_step) begin
			work_q <= div_work;
			rem_q  <= digit_done ? '0 : div_rem;
		end
	end

	// Digits are written least significant first and read back from the top.
	always_ff @(posedge clk) begin
		if (digit_done) begin
			digit_mem[cnt_q[ADDR_W-1:0]] <= div_rem;
		end
		if (rd_issue) begin
			rd_q      <= digit_mem[rd_addr];
			rd_last_q <= (cnt_q == CNT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (sign_load || dig_load) begin
			out_valid_q <= 1'b1;
		end else if (text.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sign_load) begin
			out_char_q <= MINUS_CHAR;
			out_last_q <= 1'b0;
		end else if (dig_load) begin
			out_char_q <= symbol_for(alpha_low_q, alpha_high_q, rd_q);
			out_last_q <= rd_last_q;
		end
	end

	assign text.valid     = out_valid_q;
	assign text.character = out_char_q;
	assign text.last      = out_last_q;

endmodule
`default_nettype wire

### sim/testbench.sv
// Testbench for the radix digit converter: random and directed numbers checked against a predictor.
`timescale 1ns / 1ps
module testbench;
	import itrd_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
	localparam logic signed [VALUE_W-1:0] INT_MIN_V = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] INT_MAX_V = 32'sh7FFF_FFFF;
	localparam logic [CFG_DATA_W-1:0] HEX_LOW  = 64'h3736_3534_3332_3130;
	localparam logic [CFG_DATA_W-1:0] HEX_HIGH = 64'h6665_6463_6261_3938;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 65;
	localparam int HOLD_CYCLES   = 400;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} text_char_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	itrd_value_if number_ch ();
	itrd_char_if  text_ch ();

	integer_to_radix_digits_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.number    (number_ch),
		.text      (text_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Our copy of the configuration registers, updated on every write.
	logic [RADIX_W-1:0]    radix_now;
	logic [CFG_DATA_W-1:0] alpha_low_now;
	logic [CFG_DATA_W-1:0] alpha_high_now;

	// Numbers waiting to be offered, and characters the block still owes us.
	logic signed [VALUE_W-1:0] values_to_send [$];
	text_char_t                expected_chars [$];

	int unsigned queued_count;
	int unsigned taken_count;
	int unsigned chars_seen;
	int unsigned mismatches;
	int unsigned src_gap;
	int unsigned sink_gap;
	logic        steady;
	logic        long_hold;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Looks up the byte code of a digit in the 16-entry alphabet held as one
	// 128-bit word, digit 0 in the lowest byte.
	function automatic logic [CHAR_W-1:0] alphabet_byte(input logic [DIGIT_W-1:0] d);
		logic [2*CFG_DATA_W-1:0] both;
		both = {alpha_high_now, alpha_low_now};
		return both[d * CHAR_W +: CHAR_W];
	endfunction

	// Works out the text of one number in the current radix and appends its
	// characters to the expectations, sign first, most significant digit next.
	function automatic void predict_text(input logic signed [VALUE_W-1:0] v);
		logic [VALUE_W-1:0] rest;
		logic [DIGIT_W-1:0] digits [MAX_DIGITS_DEF];
		int                 count;
		text_char_t         c;
		// Two's complement negation at 32 bits gives the right magnitude even
		// for the most negative value, since it is read back as unsigned.
		rest = $unsigned(v);
		if (v[VALUE_W-1])
			rest = ~rest + 1'b1;
		count = 0;
		do begin
			digits[count] = DIGIT_W'(rest % radix_now);
			rest = rest / radix_now;
			count++;
		end while (rest != 0 && count < MAX_DIGITS_DEF);
		if (v[VALUE_W-1]) begin
			c.character = MINUS_CHAR;
			c.last = 1'b0;
			expected_chars.push_back(c);
		end
		for (int i = count - 1; i >= 0; i--) begin
			c.character = alphabet_byte(digits[i]);
			c.last = (i == 0);
			expected_chars.push_back(c);
		end
	endfunction

	// Mostly no gap or a short one, now and then a long one; none at all
	// while a steady phase runs.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 15);
		if (steady || r < 8)
			return 0;
		if (r == 15)
			return $urandom_range(20, 60);
		return $urandom_range(1, 3);
	endfunction

	// Values for the random part: the extremes now and then, many short
	// numbers of either sign, and full-width random values for the rest.
	function automatic logic signed [VALUE_W-1:0] pick_value();
		logic signed [VALUE_W-1:0] v;
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 3))
					0: v = INT_MIN_V;
					1: v = INT_MAX_V;
					2: v = -1;
					default: v = 0;
				endcase
			end
			1, 2: begin
				v = $urandom_range(0, 400);
				if ($urandom_range(0, 1))
					v = -v;
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] %s", $time, what);
	endtask

	// One register write; the port has no wait state, so the write lands on
	// the edge after the enable is raised.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		logic [RADIX_W-1:0] r;
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_RADIX: begin
				r = data[RADIX_W-1:0];
				if (r < RADIX_MIN)
					r = RADIX_MIN;
				else if (r > MAX_RADIX_DEF)
					r = RADIX_W'(MAX_RADIX_DEF);
				radix_now = r;
			end
			REG_ALPHA_LOW: alpha_low_now = data;
			REG_ALPHA_HI:  alpha_high_now = data;
			default: ;
		endcase
	endtask

	task automatic queue_value(input logic signed [VALUE_W-1:0] v);
		values_to_send.push_back(v);
		queued_count++;
	endtask

	// Waits until every queued number has been taken and every character
	// it owes has arrived. The count of taken numbers and the expectations
	// change together in the driver, so this cannot see a false idle.
	task automatic wait_idle();
		while (taken_count != queued_count || expected_chars.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Sender: offers queued numbers with random gaps. The prediction is made
	// at the edge where the block takes a number, with the configuration in
	// force at that moment.
	always @(posedge clk) begin : drive_numbers
		logic take;
		if (arst_n) begin
			take = number_ch.valid && number_ch.ready;
			if (take) begin
				predict_text(number_ch.value);
				taken_count++;
				src_gap = pick_gap();
			end
			if (number_ch.valid && !take) begin
				// Hold the number until the block takes it.
			end else if (src_gap > 0) begin
				src_gap--;
				number_ch.valid <= 1'b0;
			end else if (values_to_send.size() > 0) begin
				number_ch.valid <= 1'b1;
				number_ch.value <= values_to_send.pop_front();
			end else begin
				number_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: checks each character against the oldest expectation and
	// stalls at random, and for a long stretch while the hold is on.
	always @(posedge clk) begin : check_text
		text_char_t want;
		if (arst_n) begin
			if (text_ch.valid && text_ch.ready) begin
				chars_seen++;
				if (expected_chars.size() == 0) begin
					flag_mismatch($sformatf("character %0d unexpected: char 0x%02h last %0b",
						chars_seen, text_ch.character, text_ch.last));
				end else begin
					want = expected_chars.pop_front();
					if (text_ch.character !== want.character || text_ch.last !== want.last)
						flag_mismatch($sformatf(
							"character %0d: expected char 0x%02h last %0b, got char 0x%02h last %0b",
							chars_seen, want.character, want.last, text_ch.character, text_ch.last));
				end
				sink_gap = pick_gap();
			end else if (sink_gap > 0) begin
				sink_gap--;
			end
			text_ch.ready <= (sink_gap == 0) && !long_hold;
		end
	end

	// Long back-pressure: once the random part is under way, the receiver
	// refuses characters for a fixed stretch while the sender keeps offering,
	// so the block fills and has to stall its number channel.
	initial begin : back_pressure
		long_hold = 1'b0;
		wait (taken_count >= 40);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	// Generous ceiling: far above the slowest correct run, where every number
	// gives 33 characters and each one waits out the longest receiver stall.
	initial begin : watchdog
		#50_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		int unsigned guard;
		arst_n          = 1'b0;
		number_ch.valid = 1'b0;
		number_ch.value = '0;
		text_ch.ready   = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		steady          = 1'b0;
		queued_count    = 0;
		taken_count     = 0;
		chars_seen      = 0;
		mismatches      = 0;
		src_gap         = 0;
		sink_gap        = 0;
		radix_now       = RADIX_RESET;
		alpha_low_now   = '0;
		alpha_high_now  = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset configuration: radix 10 and an all-zero alphabet, so only the
		// sign stands out; the digit count still shows through last.
		queue_value(0);
		queue_value(-1);
		queue_value(INT_MIN_V);
		wait_idle();

		// A radix write below the range stores 2. The most negative value
		// gives the longest text: a sign and 32 binary digits.
		write_reg(REG_RADIX, 64'd1);
		write_reg(REG_ALPHA_LOW, HEX_LOW);
		write_reg(REG_ALPHA_HI, HEX_HIGH);
		queue_value(0);
		queue_value(1);
		queue_value(-1);
		queue_value(INT_MIN_V);
		queue_value(INT_MAX_V);
		queue_value(32'sh5555_5555);
		wait_idle();

		// A radix write above the range stores 16; a write to the unused
		// index must leave everything as it was.
		write_reg(REG_RADIX, 64'd31);
		write_reg(REG_SPARE, '1);
		queue_value(INT_MIN_V);
		queue_value(INT_MAX_V);
		queue_value(0);
		queue_value(-16);
		queue_value(15);
		wait_idle();

		// Only the low five bits of the data reach the radix: zero here.
		write_reg(REG_RADIX, 64'hFFFF_FFFF_FFFF_FFE0);
		queue_value(-2);
		queue_value(2);
		wait_idle();

		// Just above the range.
		write_reg(REG_RADIX, 64'd17);
		queue_value(16);
		queue_value(-255);
		wait_idle();

		// Back to decimal with an alphabet that uses the byte extremes.
		write_reg(REG_RADIX, 64'd10);
		write_reg(REG_ALPHA_LOW, 64'h0011_2233_4455_FF00);
		write_reg(REG_ALPHA_HI, 64'hFFEE_DDCC_BBAA_0099);
		queue_value(10);
		queue_value(INT_MIN_V);
		queue_value(INT_MAX_V);
		queue_value(9);
		wait_idle();

		// Random part: a new radix and alphabet for each phase, the two radix
		// extremes first, then random data whose low bits often clamp.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0)
				write_reg(REG_RADIX, {$urandom, $urandom} & ~64'h1F | 64'd2);
			else if (p == 1)
				write_reg(REG_RADIX, 64'd16);
			else
				write_reg(REG_RADIX, {$urandom, $urandom});
			write_reg(REG_ALPHA_LOW, {$urandom, $urandom});
			write_reg(REG_ALPHA_HI, {$urandom, $urandom});
			if (p % 2 == 1)
				write_reg(REG_SPARE, {$urandom, $urandom});
			steady <= (p == 3);
			for (int k = 0; k < PHASE_ITEMS; k++)
				queue_value(pick_value());
			wait_idle();
		end

		// Allow for late or spurious characters before the verdict.
		guard = 0;
		while (guard < 20000 && (taken_count != queued_count || expected_chars.size() != 0)) begin
			@(posedge clk);
			guard++;
		end
		repeat (200) @(posedge clk);
		if (expected_chars.size() != 0) begin
			$display("%0d expected characters never arrived", expected_chars.size());
			mismatches += expected_chars.size();
		end
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### files.f
rtl/itrd_pkg.sv
rtl/itrd_if.sv
rtl/integer_to_radix_digits_core.sv
sim/testbench.sv
